>>> hw/rtl/idle_gap_packet_receiver_macros.svh
// Assertion helpers for the receiver RTL.
`ifndef IDLE_GAP_PACKET_RECEIVER_MACROS_SVH
`define IDLE_GAP_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IGPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IGPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/igpr_pkg.sv
`timescale 1ns / 1ps

package igpr_pkg;

    // Depth of the packet store and the width of a position into it.
    localparam int BUF_DEPTH = 64;
    localparam int IDX_W     = $clog2(BUF_DEPTH);

    // Fixed field widths.
    localparam int DATA_W = 8;
    localparam int RIDX_W = 6;
    localparam int LEN_W  = 6;
    localparam int GAP_W  = 8;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_GAP_TICKS = 1'b0;   // register index, taken from paddr[2]
    localparam logic [GAP_W-1:0] GAP_TICKS_RST = 8'd3;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

endpackage

>>> hw/rtl/idle_gap_packet_receiver.sv
// A transfer accepted on cmd/rx_data/... has its store read in stage one, then its result
// goes to the output register; out_stall can hold it in either. Throughput: one item per
// cycle unless out_stall holds the output; the single-port store and scalar state update
// at each accept edge, and a stage plus output register keep input and output apart.
// Reset (rst_n, asynchronous, active low): write position, ready flag and gap timer
// clear, gap_ticks returns to 3; the store contents stay undefined until written.
`timescale 1ns / 1ps
`include "idle_gap_packet_receiver_macros.svh"

module idle_gap_packet_receiver
    import igpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,

    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [DATA_W-1:0]    rx_data,
    input  logic                 framing_err,
    input  logic                 parity_err,
    input  logic                 overrun_err,
    input  logic [RIDX_W-1:0]    read_index,

    // Output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 packet_ready,
    output logic [LEN_W-1:0]     packet_length,
    output logic [DATA_W-1:0]    read_data
);

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(BUF_DEPTH - 1);
    localparam int CMP_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

    // ------------------------------------------------------------------
    // Configuration register. Only gap_ticks exists; it sits at byte
    // address 0 and any address with paddr[2] set reads as zero.
    // ------------------------------------------------------------------
    logic [GAP_W-1:0] gap_ticks_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ticks_reg <= GAP_TICKS_RST;
        end
        else if (cfg_write && (paddr[2] == REG_GAP_TICKS))
        begin
            gap_ticks_reg <= pwdata[GAP_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_GAP_TICKS)
        begin
            prdata = APB_DW'(gap_ticks_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Stage one holds the item whose store read is in flight;
    // the output register holds the result waiting to be taken. Stage one
    // moves on whenever the output register is empty or being emptied.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_advance;
    logic in_accept;

    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Scalar receive state: write position, ready flag and gap timer.
    // All updates for one item land at its accept edge, so a read that
    // follows in the next cycle already sees the new position.
    // ------------------------------------------------------------------
    cmd_t              cmd_in;
    logic              byte_bad;
    logic              byte_take;
    logic              read_hit;
    logic [IDX_W-1:0]  write_pos_reg,  write_pos_next;
    logic              ready_flag_reg, ready_flag_next;
    logic [GAP_W-1:0]  gap_timer_reg,  gap_timer_next;

    assign cmd_in    = cmd_t'(cmd);
    assign byte_bad  = framing_err || parity_err || overrun_err;
    assign byte_take = in_accept && (cmd_in == CMD_BYTE) && !ready_flag_reg && !byte_bad;
    assign read_hit  = (cmd_in == CMD_READ)
                       && (CMP_W'(read_index) < CMP_W'(write_pos_reg));

    always_comb
    begin
        write_pos_next  = write_pos_reg;
        ready_flag_next = ready_flag_reg;
        gap_timer_next  = gap_timer_reg;
        if (in_accept)
        begin
            case (cmd_in)
                CMD_BYTE:
                begin
                    if (!ready_flag_reg && !byte_bad)
                    begin
                        if (write_pos_reg < LAST_POS)
                        begin
                            write_pos_next = write_pos_reg + 1'b1;
                        end
                        gap_timer_next = gap_ticks_reg;
                    end
                end
                CMD_TICK:
                begin
                    // A tick with the timer already at zero does nothing.
                    if (gap_timer_reg != '0)
                    begin
                        gap_timer_next = gap_timer_reg - 1'b1;
                        if (gap_timer_reg == GAP_W'(1))
                        begin
                            ready_flag_next = 1'b1;
                        end
                    end
                end
                CMD_RESTART:
                begin
                    // The timer is deliberately left running.
                    write_pos_next  = '0;
                    ready_flag_next = 1'b0;
                end
                default:
                begin
                    // A read leaves the state alone.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg  <= '0;
            ready_flag_reg <= 1'b0;
            gap_timer_reg  <= '0;
        end
        else
        begin
            write_pos_reg  <= write_pos_next;
            ready_flag_reg <= ready_flag_next;
            gap_timer_reg  <= gap_timer_next;
        end
    end

    // ------------------------------------------------------------------
    // Packet store: one synchronous memory, written by accepted bytes and
    // read by read commands. Each item does at most one of the two, and
    // a write always completes at an earlier edge than any later read, so
    // no forwarding is needed.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] store_mem [BUF_DEPTH];
    logic [DATA_W-1:0] mem_q_reg;
    logic              mem_re;

    assign mem_re = in_accept && read_hit;

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            store_mem[write_pos_reg] <= rx_data;
        end
        if (mem_re)
        begin
            mem_q_reg <= store_mem[IDX_W'(read_index)];
        end
    end

    // ------------------------------------------------------------------
    // Stage one: the result fields that are known at accept time, plus a
    // flag telling whether the store output belongs to this item.
    // ------------------------------------------------------------------
    logic              s1_ready_reg;
    logic [LEN_W-1:0]  s1_length_reg;
    logic              s1_use_mem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ready_reg   <= ready_flag_next && (write_pos_next != '0);
            s1_length_reg  <= LEN_W'(write_pos_next);
            s1_use_mem_reg <= read_hit;
        end
    end

    // ------------------------------------------------------------------
    // Output register. Reads past the length and all non-read commands
    // report zero data.
    // ------------------------------------------------------------------
    logic              out_ready_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_load;

    assign out_load = s1_valid_reg && s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ready_reg  <= s1_ready_reg;
            out_length_reg <= s1_length_reg;
            out_data_reg   <= s1_use_mem_reg ? mem_q_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign packet_ready  = out_ready_reg;
    assign packet_length = out_length_reg;
    assign read_data     = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IGPR_ASSERT_NOW(a_pos_in_range, 1'b1, write_pos_reg <= LAST_POS,
        "write position ran past the last slot")
    `IGPR_ASSERT_NOW(a_ready_timer_idle, ready_flag_reg, gap_timer_reg == '0,
        "ready flag set while gap timer still running")
    `IGPR_ASSERT_NOW(a_full_pipe_stalls, s1_valid_reg && out_valid_reg && out_stall,
        in_stall, "input not stalled with both stages full")
    `IGPR_ASSERT_NEXT(a_restart_clears, in_accept && (cmd_in == CMD_RESTART),
        (write_pos_reg == '0) && !ready_flag_reg, "restart did not clear the packet")

endmodule

>>> bench/tb_idle_gap_packet_receiver.sv
`timescale 1ns / 1ps

module tb_idle_gap_packet_receiver;

    import igpr_pkg::*;

    // How long the receiver holds off during a pressure stretch.
    localparam int HOLD_CYCLES  = 120;
    // Counted transfers per configuration phase of the random part.
    localparam int PHASE_ITEMS  = 140;
    // How long to keep watching the output once nothing is expected any more.
    localparam int DRAIN_CYCLES = 12;

    // One input transfer, field by field.
    typedef struct {
        cmd_t              cmd;
        logic [DATA_W-1:0] data;
        logic              frame_err;
        logic              par_err;
        logic              ovr_err;
        logic [RIDX_W-1:0] ridx;
    } rx_item_t;

    // One output transfer, field by field.
    typedef struct {
        logic              ready;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data;
    } rx_result_t;

    // The scoreboard keeps its own copy of the framer state. Each accepted input
    // transfer is run through that copy, and the result it must produce is queued
    // until the matching output transfer arrives.
    class packet_scoreboard;
        logic [DATA_W-1:0] store [BUF_DEPTH];
        logic [IDX_W-1:0]  fill;
        logic              done;
        logic [GAP_W-1:0]  timer;
        logic [GAP_W-1:0]  gap;
        rx_result_t        expected_q[$];
        int unsigned       fail_count;

        function new();
            foreach (store[i])
                store[i] = '0;
            fill       = '0;
            done       = 1'b0;
            timer      = '0;
            gap        = GAP_TICKS_RST;
            fail_count = 0;
        endfunction

        function void set_gap(logic [GAP_W-1:0] value);
            gap = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [IDX_W-1:0] length();
            return fill;
        endfunction

        task report(string msg);
            if (fail_count < 50)
                $display("[%0t] error: %s", $realtime, msg);
            fail_count++;
        endtask

        // Advances the copy of the state by one transfer and queues the result.
        // Returns 0 for a byte or tick that left the state untouched.
        function bit note_input(rx_item_t it);
            rx_result_t res;
            bit         acted;
            acted    = 1'b1;
            res.data = '0;
            case (it.cmd)
                CMD_BYTE:
                begin
                    if (!done && !(it.frame_err || it.par_err || it.ovr_err))
                    begin
                        store[fill] = it.data;
                        if (fill < BUF_DEPTH - 1)
                            fill++;
                        timer = gap;
                    end
                    else
                        acted = 1'b0;
                end
                CMD_TICK:
                begin
                    if (timer != 0)
                    begin
                        timer--;
                        if (timer == 0)
                            done = 1'b1;
                    end
                    else
                        acted = 1'b0;
                end
                CMD_RESTART:
                begin
                    fill = '0;
                    done = 1'b0;
                end
                default:
                begin
                    if (it.ridx < fill)
                        res.data = store[it.ridx];
                end
            endcase
            res.ready  = done && (fill != 0);
            res.length = fill;
            expected_q.push_back(res);
            return acted;
        endfunction

        task check_result(rx_result_t got);
            rx_result_t want;
            if (expected_q.size() == 0)
            begin
                report("output transfer with no result expected");
                return;
            end
            want = expected_q.pop_front();
            if (got.ready !== want.ready)
                report($sformatf("packet_ready %0b, expected %0b", got.ready, want.ready));
            if (got.length !== want.length)
                report($sformatf("packet_length %0d, expected %0d", got.length, want.length));
            if (got.data !== want.data)
                report($sformatf("read_data %02h, expected %02h", got.data, want.data));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           cmd;
    logic [DATA_W-1:0]    rx_data;
    logic                 framing_err;
    logic                 parity_err;
    logic                 overrun_err;
    logic [RIDX_W-1:0]    read_index;
    logic                 out_valid;
    logic                 out_stall;
    logic                 packet_ready;
    logic [LEN_W-1:0]     packet_length;
    logic [DATA_W-1:0]    read_data;

    packet_scoreboard sb = new();

    // Sender pacing: transfers go out in bursts, and no_gaps turns the pauses off.
    int unsigned      burst_left = 0;
    bit               no_gaps    = 1'b0;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit               hold_req   = 1'b0;
    // Input transfers that changed the framer state or read from it.
    int unsigned      live_items = 0;
    // The silence length currently programmed into the block.
    logic [GAP_W-1:0] cur_gap    = GAP_TICKS_RST;

    idle_gap_packet_receiver u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A fixed limit far beyond the slowest correct run ends a hung simulation.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Every output transfer is checked against the oldest queued result. Outputs
    // are sampled right after the edge, so the values seen are the ones that
    // the edge itself took.
    always @(posedge clk)
    begin
        rx_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.ready  = packet_ready;
            got.length = packet_length;
            got.data   = read_data;
            sb.check_result(got);
        end
    end

    // The receiver stalls on a pattern of its own, picked anew for each segment of random
    // length: no stalls at all, sparse stalls, heavy stalls, or a regular beat.
    // When asked, it holds off completely for a pressure stretch, so that the
    // block fills up and has to stall its own input.
    initial
    begin : receiver
        int seg_left;
        int mode;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(5, 60);
                    mode     = $urandom_range(0, 3);
                end
                seg_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    function automatic rx_item_t mk(cmd_t c, logic [DATA_W-1:0] d, logic [2:0] errs,
                                    logic [RIDX_W-1:0] r);
        rx_item_t it;
        it.cmd       = c;
        it.data      = d;
        it.frame_err = errs[2];
        it.par_err   = errs[1];
        it.ovr_err   = errs[0];
        it.ridx      = r;
        return it;
    endfunction

    // Every field random; the fields that the command does not use are random too.
    function automatic rx_item_t rand_item(cmd_t c);
        return mk(c, DATA_W'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  RIDX_W'($urandom_range(0, 63)));
    endfunction

    // A read that mostly lands inside the stored packet, and sometimes anywhere.
    function automatic rx_item_t read_item();
        rx_item_t         it;
        logic [IDX_W-1:0] len;
        it  = rand_item(CMD_READ);
        len = sb.length();
        if (len != 0 && $urandom_range(0, 3) != 0)
            it.ridx = RIDX_W'($urandom_range(0, len - 1));
        return it;
    endfunction

    // Offers one transfer and waits until the block takes it. A pause, when one
    // falls due, drops valid first; back-to-back transfers keep valid high, so
    // valid gets at most one assignment in any time step.
    task automatic send_item(input rx_item_t it);
        int gap;
        gap = 0;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= it.cmd;
        rx_data     <= it.data;
        framing_err <= it.frame_err;
        parity_err  <= it.par_err;
        overrun_err <= it.ovr_err;
        read_index  <= it.ridx;
        do
            @(posedge clk);
        while (in_stall);
        if (sb.note_input(it))
            live_items++;
    endtask

    // Programs the silence length once the block has drained, then reads it back.
    task automatic write_gap_ticks(input logic [GAP_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_GAP_TICKS, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[GAP_W-1:0] !== value)
            sb.report($sformatf("gap_ticks reads %0d, written %0d", prdata[GAP_W-1:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_gap(value);
        cur_gap = value;
    endtask

    // One well-formed packet: a restart, a run of bytes with the odd bad byte,
    // stray tick or early read, then enough silence to end the packet, a few
    // bytes that must be ignored while it is ready, and reads of its contents.
    // Now and then the packet is long enough to fill the store.
    task automatic run_packet();
        rx_item_t it;
        int       n;
        send_item(rand_item(CMD_RESTART));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
        repeat (n)
        begin
            it = rand_item(CMD_BYTE);
            if ($urandom_range(0, 9) != 0)
                {it.frame_err, it.par_err, it.ovr_err} = 3'b000;
            send_item(it);
            case ($urandom_range(0, 15))
                0:       send_item(rand_item(CMD_TICK));
                1:       send_item(read_item());
                default: ;
            endcase
        end
        repeat (int'(cur_gap) + $urandom_range(0, 2))
            send_item(rand_item(CMD_TICK));
        repeat ($urandom_range(0, 3))
        begin
            it = rand_item(CMD_BYTE);
            if ($urandom_range(0, 1) != 0)
                {it.frame_err, it.par_err, it.ovr_err} = 3'b000;
            send_item(it);
        end
        repeat ($urandom_range(2, 6))
            send_item(read_item());
    endtask

    // Back-to-back transfers while the receiver holds off.
    task automatic squeeze_output();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (24)
            send_item(rand_item(cmd_t'($urandom_range(0, 3))));
        no_gaps = 1'b0;
    endtask

    initial
    begin : stimulus
        int          plan [7];
        int unsigned phase_start;
        plan = '{1, 255, 5, 2, 0, 3, 17};

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        cmd         <= CMD_BYTE;
        rx_data     <= '0;
        framing_err <= 1'b0;
        parity_err  <= 1'b0;
        overrun_err <= 1'b0;
        read_index  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset silence length of three ticks.
        // A read and a tick before anything is stored.
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd63));
        send_item(mk(CMD_TICK, 8'hFF, 3'b111, 6'd0));
        // Good bytes at both extremes, then one byte for each kind of error.
        send_item(mk(CMD_BYTE, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_BYTE, 8'hFF, 3'b000, 6'd63));
        send_item(mk(CMD_BYTE, 8'h3C, 3'b100, 6'd0));
        send_item(mk(CMD_BYTE, 8'hC3, 3'b010, 6'd0));
        send_item(mk(CMD_BYTE, 8'h96, 3'b001, 6'd0));
        send_item(mk(CMD_BYTE, 8'hA5, 3'b000, 6'd0));
        // Reads inside the packet, at its length, and at the top index.
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd1));
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd2));
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd3));
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd63));
        // Two ticks of silence, then a byte that reloads the timer.
        send_item(mk(CMD_TICK, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_TICK, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_BYTE, 8'h5A, 3'b000, 6'd0));
        // Three more ticks end the packet.
        send_item(mk(CMD_TICK, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_TICK, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_TICK, 8'h00, 3'b000, 6'd0));
        // A byte while the packet is ready must be dropped, and a tick with the
        // timer already at zero must leave the ready flag alone.
        send_item(mk(CMD_BYTE, 8'h11, 3'b000, 6'd0));
        send_item(mk(CMD_TICK, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd3));
        // After a restart the old contents are out of reach.
        send_item(mk(CMD_RESTART, 8'h00, 3'b000, 6'd0));
        send_item(mk(CMD_READ, 8'h00, 3'b000, 6'd0));

        // Random part, one phase per silence length, the extremes among them.
        for (int p = 0; p < 7; p++)
        begin
            write_gap_ticks((p == 4) ? GAP_W'($urandom_range(1, 40)) : GAP_W'(plan[p]));
            phase_start = live_items;
            if (p == 2 || p == 5)
                squeeze_output();
            while (live_items - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: any command with any content.
                    repeat ($urandom_range(5, 15))
                        send_item(rand_item(cmd_t'($urandom_range(0, 3))));
                end
                else
                    run_packet();
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> idle_gap_packet_receiver.f
+incdir+hw/rtl
hw/rtl/igpr_pkg.sv
hw/rtl/idle_gap_packet_receiver.sv
bench/tb_idle_gap_packet_receiver.sv
